>>> rtl/arpc_pkg.sv
// Shared types and constants for the ARP cache table.
// Used by the channel interfaces, the entry store and the top level.
package arpc_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IP_W        = 32;
  localparam int MAC_W       = 48;
  localparam int STATUS_W    = 3;
  localparam int SLOT_W      = 8;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_state_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] addr;
  } mem_req_t;

endpackage

>>> rtl/arpc_req_if.sv
// Request channel: one insert or lookup item with valid/ready handshake.
// Depends on arpc_pkg for field widths.
interface arpc_req_if;
  import arpc_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [IP_W-1:0]  key_ip;
  logic [MAC_W-1:0] mac_addr;

  modport source (output valid, mode, key_ip, mac_addr, input ready);
  modport sink   (input valid, mode, key_ip, mac_addr, output ready);
endinterface

>>> rtl/arpc_rsp_if.sv
// Result channel: status, matched MAC and slot with valid/ready handshake.
// Depends on arpc_pkg for field widths.
interface arpc_rsp_if;
  import arpc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [MAC_W-1:0]    found_mac;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, status, found_mac, slot, input ready);
  modport sink   (input valid, status, found_mac, slot, output ready);
endinterface

>>> rtl/arpc_store.sv
// Entry store: IP and MAC memories sharing one address, with a registered read.
// Depends on arpc_pkg for widths and the mem_req_t request struct.
module arpc_store (
  input  logic                       clk,
  input  arpc_pkg::mem_req_t         req,
  input  logic [arpc_pkg::IP_W-1:0]  wr_ip,
  input  logic [arpc_pkg::MAC_W-1:0] wr_mac,
  output logic [arpc_pkg::IP_W-1:0]  rd_ip,
  output logic [arpc_pkg::MAC_W-1:0] rd_mac
);
  import arpc_pkg::*;

  logic [IP_W-1:0]  ip_mem  [TABLE_DEPTH];
  logic [MAC_W-1:0] mac_mem [TABLE_DEPTH];
  logic [IP_W-1:0]  rd_ip_r;
  logic [MAC_W-1:0] rd_mac_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      ip_mem[req.addr]  <= wr_ip;
      mac_mem[req.addr] <= wr_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_ip_r  <= ip_mem[req.addr];
      rd_mac_r <= mac_mem[req.addr];
    end
  end

  assign rd_ip  = rd_ip_r;
  assign rd_mac = rd_mac_r;

endmodule

>>> rtl/arp_cache_table.sv
// ARP cache table top level: IPv4 to MAC map with insert and lookup items.
// Depends on arpc_pkg, arpc_req_if, arpc_rsp_if and arpc_store.
//
// Usage:
//   in_ch carries one item per handshake: mode (0 insert, 1 lookup), key_ip
//   and mac_addr. out_ch returns exactly one item per request: status,
//   found_mac and slot. An item is taken when valid and ready are both high.
//   Entries fill in order from slot 0 and are never removed, so a fill count
//   marks the occupied prefix of the store; no clearing pass runs.
//   An item with key_ip zero skips the scan and goes straight to its result:
//   a miss, or full for an insert. Otherwise the block reads one entry per
//   cycle from the store (one read port, registered read) over the N occupied
//   entries, stopping at the first match. An insert writes its entry in the
//   cycle the result is loaded into the output register.
//   One item is in work at a time; the next is taken as soon as the result
//   sits in the output register, even while the receiver has not taken it.
//   Reset empties the table and drops any pending result. A stalled receiver
//   holds the result register; a finished item then waits, with its write.
module arp_cache_table (
  input logic        clk,
  input logic        rst_n,
  arpc_req_if.sink   in_ch,
  arpc_rsp_if.source out_ch
);
  import arpc_pkg::*;

  fsm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;

  logic             mode_r;
  logic [IP_W-1:0]  key_r;
  logic [MAC_W-1:0] mac_r;

  status_t          res_status_r, res_status_nxt;
  logic [MAC_W-1:0] res_mac_r, res_mac_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic             wr_pend_r, wr_pend_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [MAC_W-1:0]    out_mac_r;
  logic [SLOT_W-1:0]   out_slot_r;

  mem_req_t         mem_req;
  logic [IP_W-1:0]  rd_ip;
  logic [MAC_W-1:0] rd_mac;

  logic accept;
  logic hit;
  logic scan_end;
  logic out_free;
  logic has_room;

  assign accept   = in_ch.valid && in_ch.ready;
  assign hit      = pend_r && (rd_ip == key_r);
  assign scan_end = !hit && (rd_idx_r == fill_r);
  assign out_free = !out_valid_r || out_ch.ready;
  assign has_room = (fill_r != CNT_W'(TABLE_DEPTH));

  assign in_ch.ready = (state_r == FSM_IDLE);

  arpc_store u_store (
    .clk    (clk),
    .req    (mem_req),
    .wr_ip  (key_r),
    .wr_mac (mac_r),
    .rd_ip  (rd_ip),
    .rd_mac (rd_mac)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.key_ip == '0) ? FSM_DONE : FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (hit || scan_end) begin
          state_nxt = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (out_free) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    rd_idx_nxt     = rd_idx_r;
    pend_nxt       = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    fill_nxt       = fill_r;
    res_status_nxt = res_status_r;
    res_mac_nxt    = res_mac_r;
    res_slot_nxt   = res_slot_r;
    wr_pend_nxt    = wr_pend_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    mem_req        = '0;
    mem_req.addr   = rd_idx_r[IDX_W-1:0];
    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          rd_idx_nxt     = '0;
          wr_pend_nxt    = 1'b0;
          res_mac_nxt    = '0;
          res_slot_nxt   = '0;
          res_status_nxt = (in_ch.mode == MODE_INSERT) ? ST_FULL : ST_MISS;
        end
      end
      FSM_SCAN: begin
        if (hit) begin
          res_slot_nxt = SLOT_W'(cmp_idx_r);
          if (mode_r == MODE_INSERT) begin
            res_status_nxt = ST_PRESENT;
          end else begin
            res_status_nxt = ST_HIT;
            res_mac_nxt    = rd_mac;
          end
        end else if (scan_end) begin
          if (mode_r == MODE_INSERT && has_room) begin
            res_status_nxt = ST_INSERTED;
            res_slot_nxt   = SLOT_W'(fill_r[IDX_W-1:0]);
            wr_pend_nxt    = 1'b1;
          end
        end else begin
          mem_req.rd_en = 1'b1;
          cmp_idx_nxt   = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt    = rd_idx_r + 1'b1;
          pend_nxt      = 1'b1;
        end
      end
      FSM_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (wr_pend_r) begin
            mem_req.wr_en = 1'b1;
            mem_req.addr  = fill_r[IDX_W-1:0];
            fill_nxt      = fill_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_mac_r    <= res_mac_nxt;
    res_slot_r   <= res_slot_nxt;
    if (accept) begin
      mode_r <= in_ch.mode;
      key_r  <= in_ch.key_ip;
      mac_r  <= in_ch.mac_addr;
    end
    if (state_r == FSM_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_mac_r    <= res_mac_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.found_mac = out_mac_r;
  assign out_ch.slot      = out_slot_r;

endmodule
